FILE: src/lps_pkg.sv
package lps_pkg;

  localparam int XY_W  = 16;
  localparam int EXT_W = 7;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } lps_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } lps_cmd_t;

  typedef struct packed {
    logic last;
  } lps_stat_t;

endpackage

FILE: src/lps_ctrl.sv
module lps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lps_pkg::lps_stat_t stat,
  output lps_pkg::lps_cmd_t  cmd,
  output logic              busy
);
  import lps_pkg::*;

  lps_state_t state_r, state_nxt;
  logic       run;

  assign run      = (state_r == ST_RUN);
  // The final pixel's cycle frees the block, so the next line can load behind it.
  assign busy     = run & ~stat.last;
  assign cmd.load = start & ~busy;
  assign cmd.step = run;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (stat.last && !cmd.load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/lps_datapath.sv
module lps_datapath #(
  parameter int MAX_SPAN   = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lps_pkg::lps_cmd_t                      cmd,
  input  logic signed [lps_pkg::XY_W-1:0]        in_start_x,
  input  logic signed [lps_pkg::XY_W-1:0]        in_start_y,
  input  logic signed [lps_pkg::EXT_W-1:0]       in_extent_x,
  input  logic signed [lps_pkg::EXT_W-1:0]       in_extent_y,
  output lps_pkg::lps_stat_t                     stat,
  output logic signed [lps_pkg::XY_W-1:0]        out_pixel_x,
  output logic signed [lps_pkg::XY_W-1:0]        out_pixel_y
);
  import lps_pkg::*;

  localparam int SPAN_W = $clog2(MAX_SPAN + 1);
  localparam int PAD_W  = (COORD_BITS > XY_W) ? COORD_BITS : XY_W;

  logic [COORD_BITS-1:0] px_r, py_r, px_nxt, py_nxt;
  logic                  nx_r, ny_r, xmaj_r;
  logic [SPAN_W-1:0]     major_r, minor_r, rem_r;
  logic [SPAN_W:0]       err_r, err_nxt, err_sum;
  logic                  err_wrap;

  logic [EXT_W-1:0]      mag_x, mag_y;
  logic [SPAN_W-1:0]     cnt_x, cnt_y;
  logic [PAD_W-1:0]      sx_ext, sy_ext, px_ext, py_ext;

  function automatic logic [EXT_W-1:0] ext_mag(input logic [EXT_W-1:0] v);
    // The most negative code yields its full magnitude as an unsigned value.
    return v[EXT_W-1] ? (EXT_W'(0) - v) : v;
  endfunction

  function automatic logic [SPAN_W-1:0] span_count(input logic [EXT_W-1:0] m);
    logic [SPAN_W-1:0] s;
    if (32'(m) > 32'(MAX_SPAN - 1)) s = SPAN_W'(MAX_SPAN - 1);
    else s = SPAN_W'(m);
    return s + SPAN_W'(1);
  endfunction

  function automatic logic [COORD_BITS-1:0] step_coord(input logic [COORD_BITS-1:0] c,
                                                       input logic neg);
    return neg ? (c - COORD_BITS'(1)) : (c + COORD_BITS'(1));
  endfunction

  assign mag_x  = ext_mag($unsigned(in_extent_x));
  assign mag_y  = ext_mag($unsigned(in_extent_y));
  assign cnt_x  = span_count(mag_x);
  assign cnt_y  = span_count(mag_y);
  assign sx_ext = PAD_W'($unsigned(in_start_x));
  assign sy_ext = PAD_W'($unsigned(in_start_y));

  assign err_sum  = err_r + {1'b0, minor_r};
  assign err_wrap = (err_sum >= {1'b0, major_r});
  assign err_nxt  = err_wrap ? (err_sum - {1'b0, major_r}) : err_sum;

  always_comb begin
    px_nxt = px_r;
    py_nxt = py_r;
    if (xmaj_r) begin
      px_nxt = step_coord(px_r, nx_r);
      if (err_wrap) py_nxt = step_coord(py_r, ny_r);
    end else begin
      py_nxt = step_coord(py_r, ny_r);
      if (err_wrap) px_nxt = step_coord(px_r, nx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r    <= COORD_BITS'(sx_ext);
      py_r    <= COORD_BITS'(sy_ext);
      nx_r    <= in_extent_x[EXT_W-1];
      ny_r    <= in_extent_y[EXT_W-1];
      xmaj_r  <= (cnt_x >= cnt_y);
      major_r <= (cnt_x >= cnt_y) ? cnt_x : cnt_y;
      minor_r <= (cnt_x >= cnt_y) ? cnt_y : cnt_x;
      rem_r   <= (cnt_x >= cnt_y) ? cnt_x : cnt_y;
      err_r   <= '0;
    end else if (cmd.step) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      rem_r <= rem_r - SPAN_W'(1);
      err_r <= err_nxt;
    end
  end

  assign stat.last   = (rem_r == SPAN_W'(1));
  assign px_ext      = PAD_W'(px_r);
  assign py_ext      = PAD_W'(py_r);
  assign out_pixel_x = $signed(px_ext[XY_W-1:0]);
  assign out_pixel_y = $signed(py_ext[XY_W-1:0]);

  a_err_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (err_r < {1'b0, major_r}))
    else $error("error accumulator not below major count");

  a_rem_live : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (rem_r != '0))
    else $error("pixel emitted with no pixels remaining");

  a_minor_le : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (minor_r <= major_r))
    else $error("minor count exceeds major count");

  a_rem_dec : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !cmd.load) |=> (rem_r == $past(rem_r) - SPAN_W'(1)))
    else $error("remaining count did not step down");

endmodule

FILE: src/line_pixel_stepper.sv
// Channel   Handshake              Payload
// input     start, busy            in_start_x, in_start_y, in_extent_x, in_extent_y
// result    out_valid (strobe)     out_pixel_x, out_pixel_y, out_last_pixel
//
// A line of N pixels (N = larger of |extent|+1 per axis, at most MAX_SPAN) is
// emitted one pixel per cycle, starting the cycle after the request is taken.
// The stepping counter counts down the N pixels of a line, and the next request
// is taken during the final pixel's cycle, so lines follow with no gap.
// Reset (synchronous, active low) returns the controller to idle; no results
// are in flight afterward. The receiver cannot stall, so no output buffering.
module line_pixel_stepper #(
  parameter int MAX_SPAN   = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [lps_pkg::XY_W-1:0]   in_start_x,
  input  logic signed [lps_pkg::XY_W-1:0]   in_start_y,
  input  logic signed [lps_pkg::EXT_W-1:0]  in_extent_x,
  input  logic signed [lps_pkg::EXT_W-1:0]  in_extent_y,
  output logic                              out_valid,
  output logic signed [lps_pkg::XY_W-1:0]   out_pixel_x,
  output logic signed [lps_pkg::XY_W-1:0]   out_pixel_y,
  output logic                              out_last_pixel
);
  import lps_pkg::*;

  lps_cmd_t  cmd;
  lps_stat_t stat;

  lps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lps_datapath #(
    .MAX_SPAN   (MAX_SPAN),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_start_x  (in_start_x),
    .in_start_y  (in_start_y),
    .in_extent_x (in_extent_x),
    .in_extent_y (in_extent_y),
    .stat        (stat),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y)
  );

  assign out_valid      = cmd.step;
  assign out_last_pixel = cmd.step & stat.last;

endmodule
